[hw/rtl/necir_pkg.sv]
// nec infrared frame decoder package: codes, widths and reset values
// no dependencies
`timescale 1ns / 1ps

package necir_pkg;

    localparam int unsigned TICK_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W    = 8;

    localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;

    // command codes
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_RECV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_HELD = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX      = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_PREAMBLE_MIN = 8'd180;
    localparam logic [CFG_W-1:0] RST_PREAMBLE_MAX = 8'd243;
    localparam logic [CFG_W-1:0] RST_ZERO_MIN     = 8'd14;
    localparam logic [CFG_W-1:0] RST_ZERO_MAX     = 8'd20;
    localparam logic [CFG_W-1:0] RST_ONE_MIN      = 8'd29;
    localparam logic [CFG_W-1:0] RST_ONE_MAX      = 8'd41;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RECV = 3'b010,
        ST_HELD = 3'b100
    } t_mode;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode mode);
        logic [MODE_W-1:0] code;
        unique case (mode)
            ST_IDLE: code = MODE_CODE_IDLE;
            ST_RECV: code = MODE_CODE_RECV;
            ST_HELD: code = MODE_CODE_HELD;
            default: code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/necir_in_if.sv]
// input channel of the nec infrared frame decoder: valid, ready, edge item
// depends on necir_pkg
`timescale 1ns / 1ps

interface necir_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [necir_pkg::TICK_W-1:0]     interval_ticks;
    logic                             timer_overflow;

    modport source (output valid, output cmd, output interval_ticks,
                    output timer_overflow, input ready);
    modport sink   (input valid, input cmd, input interval_ticks,
                    input timer_overflow, output ready);
endinterface

[hw/rtl/necir_out_if.sv]
// result channel of the nec infrared frame decoder: valid, ready, decoded frame
// depends on necir_pkg
`timescale 1ns / 1ps

interface necir_out_if;
    logic                             valid;
    logic                             ready;
    logic [necir_pkg::MODE_W-1:0]     rx_mode;
    logic                             frame_done;
    logic [necir_pkg::WORD_W-1:0]     code_word;
    logic [7:0]                       command_byte;
    logic [15:0]                      address_word;

    modport source (output valid, output rx_mode, output frame_done,
                    output code_word, output command_byte,
                    output address_word, input ready);
    modport sink   (input valid, input rx_mode, input frame_done,
                    input code_word, input command_byte,
                    input address_word, output ready);
endinterface

[hw/rtl/nec_ir_frame_decoder_top.sv]
// nec infrared frame decoder top level: window compare, shift word, frame check
// depends on necir_pkg, necir_in_if, necir_out_if
`timescale 1ns / 1ps

// Usage
//   i_in carries one transaction per falling-edge event (cmd edge) with the
//   tick interval and the timer overflow flag, or a release (cmd release)
//   that frees a held frame. o_out returns exactly one transaction per input
//   transaction: mode after the item, frame done flag and the shift word.
//   i_cfg_we / i_cfg_idx / i_cfg_data write the six window registers
//   (preamble, zero, one; min and max, inclusive); write only while idle.
// Output timing and throughput
//   the registered result appears on o_out in the cycle after the input;
//   one transaction per cycle unless o_out stalls; single output register stage.
// Reset
//   i_rst_n low at a clock edge: mode idle, bit count and word cleared,
//   windows back to their defaults, output register empty.
// Stall
//   while o_out holds a result that is not taken, i_in.ready is low;
//   it rises in the same cycle in which the receiver takes the result.
module nec_ir_frame_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    necir_in_if.sink                          i_in,
    necir_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [necir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [necir_pkg::CFG_W-1:0]       i_cfg_data
);
    import necir_pkg::*;

    logic [CFG_W-1:0]  r_pre_min, r_pre_max, r_zero_min, r_zero_max;
    logic [CFG_W-1:0]  r_one_min, r_one_max;

    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_word, n_word;
    logic              n_done;

    logic              r_out_valid;
    logic [MODE_W-1:0] r_out_mode;
    logic              r_out_done;
    logic [WORD_W-1:0] r_out_word;

    logic              in_accept;
    logic              is_pre, is_zero, is_one;
    logic [CNT_W-1:0]  cnt_inc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign is_pre  = !i_in.timer_overflow && (i_in.interval_ticks >= r_pre_min)
                     && (i_in.interval_ticks <= r_pre_max);
    assign is_zero = !i_in.timer_overflow && (i_in.interval_ticks >= r_zero_min)
                     && (i_in.interval_ticks <= r_zero_max);
    assign is_one  = !i_in.timer_overflow && (i_in.interval_ticks >= r_one_min)
                     && (i_in.interval_ticks <= r_one_max);
    assign cnt_inc = r_cnt + 6'd1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_min  <= RST_PREAMBLE_MIN;
            r_pre_max  <= RST_PREAMBLE_MAX;
            r_zero_min <= RST_ZERO_MIN;
            r_zero_max <= RST_ZERO_MAX;
            r_one_min  <= RST_ONE_MIN;
            r_one_max  <= RST_ONE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PREAMBLE_MIN: r_pre_min  <= i_cfg_data;
                REG_PREAMBLE_MAX: r_pre_max  <= i_cfg_data;
                REG_ZERO_MIN:     r_zero_min <= i_cfg_data;
                REG_ZERO_MAX:     r_zero_max <= i_cfg_data;
                REG_ONE_MIN:      r_one_min  <= i_cfg_data;
                REG_ONE_MAX:      r_one_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state for one item
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_done = 1'b0;
        if (i_in.cmd == CMD_RELEASE) begin
            if (r_mode == ST_HELD) begin
                n_mode = ST_IDLE;
            end
        end else begin
            unique case (r_mode)
                ST_IDLE: begin
                    if (is_pre) begin
                        n_cnt  = '0;
                        n_mode = ST_RECV;
                    end
                end
                ST_RECV: begin
                    n_word = {r_word[WORD_W-2:0], is_one};
                    if (is_one || is_zero) begin
                        n_cnt = cnt_inc;
                        if (cnt_inc == FRAME_BITS) begin
                            if (n_word[15:8] == ~n_word[7:0]) begin
                                n_mode = ST_HELD;
                                n_done = 1'b1;
                            end else begin
                                n_mode = ST_IDLE;
                            end
                        end
                    end else begin
                        n_mode = ST_IDLE;
                    end
                end
                ST_HELD: ;
                default: n_mode = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE;
            r_cnt  <= '0;
            r_word <= '0;
        end else if (in_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_word <= n_word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_mode <= mode_code(n_mode);
            r_out_done <= n_done;
            r_out_word <= n_word;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rx_mode      = r_out_mode;
    assign o_out.frame_done   = r_out_done;
    assign o_out.code_word    = r_out_word;
    assign o_out.command_byte = r_out_word[15:8];
    assign o_out.address_word = r_out_word[31:16];

endmodule

[hw/rtl/necir_checker.sv]
// port-level checks for the nec infrared frame decoder, bound to the top level
// depends on necir_pkg
`timescale 1ns / 1ps

module necir_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [necir_pkg::MODE_W-1:0]   i_rx_mode,
    input  logic                           i_frame_done,
    input  logic [necir_pkg::WORD_W-1:0]   i_code_word
);
    import necir_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a completed frame always leaves the block holding it
    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_done) |-> (i_rx_mode == MODE_CODE_HELD))
        else $error("frame done without held mode");

    // a completed frame passed the command check
    a_done_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_done) |-> (i_code_word[15:8] == ~i_code_word[7:0]))
        else $error("frame done with bad command complement");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_code_word) && $stable(i_rx_mode)))
        else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder_top necir_checker u_necir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_rx_mode    (o_out.rx_mode),
    .i_frame_done (o_out.frame_done),
    .i_code_word  (o_out.code_word)
);
